// ===== rtl/assert_macros.svh =====
// Assertion helpers, clocked on clk, quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ORNR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be seen
`define ORNR_NEVER(label, cond, msg) \
	`ORNR_ASSERT(label, !(cond), msg)

`endif

// ===== rtl/ornr_pkg.sv =====
package ornr_pkg;

	localparam int PARTITIONS = 16;
	// quotient bits needed before saturation
	localparam int QW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
	// sat check stage plus one restoring step per quotient bit, plus issue register
	localparam int NS = QW + 2;
	localparam int DW = 32 + QW;

	localparam logic [1:0] CFG_BATCH    = 2'd0;
	localparam logic [1:0] CFG_MIN_LEN  = 2'd1;
	localparam logic [1:0] CFG_WIN_LOW  = 2'd2;
	localparam logic [1:0] CFG_WIN_HIGH = 2'd3;

	typedef struct packed {
		logic signed [31:0] score;
		logic [30:0] qid;
		logic [30:0] qsz;
		logic [30:0] sid;
		logic [30:0] ssz;
		logic [1:0]  strands;
		logic [63:0] qrng;
		logic [30:0] qoff;
		logic [63:0] srng;
		logic [30:0] soff;
	} rec_t;

	typedef struct packed {
		logic        valid;
		logic        last;
		logic [30:0] rel;
		rec_t        view;
	} iss_t;

	typedef struct packed {
		logic [30:0]   rem;
		logic [30:0]   dvs;
		logic [QW-1:0] q;
		logic          sat;
		logic          last;
	} dv_t;

	function automatic logic [63:0] flip_range(input logic [30:0] size, input logic [63:0] rng);
		logic [31:0] sz;
		sz = {1'b0, size};
		return {sz - rng[31:0], sz - rng[63:32]};
	endfunction

	function automatic logic [30:0] flip_off(input logic [30:0] size, input logic [30:0] off);
		return size - off;
	endfunction

	// turn the view so the subject reads forward
	function automatic rec_t normalize(input rec_t r);
		rec_t o;
		o = r;
		o.strands[1] = 1'b0;
		if (r.strands[1]) begin
			o.strands[0] = ~r.strands[0];
			o.qrng = flip_range(r.qsz, r.qrng);
			o.qoff = flip_off(r.qsz, r.qoff);
			o.srng = flip_range(r.ssz, r.srng);
			o.soff = flip_off(r.ssz, r.soff);
		end
		return o;
	endfunction

endpackage

// ===== rtl/ornr_split.sv =====
// Holds one request and issues its swapped and/or direct view, one per cycle while take is high.
module ornr_split (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  ornr_pkg::rec_t item,
	input  logic [30:0]   min_len,
	input  logic [30:0]   win_low,
	input  logic [30:0]   win_high,
	input  logic          take,
	output ornr_pkg::iss_t iss
);
	import ornr_pkg::*;

	logic [1:0] pend_q;   // bit0 swapped view due, bit1 direct view due
	rec_t       item_q;
	rec_t       view;
	logic       accept, issue, qwin, swin, drop;
	logic [30:0] route_id;

	assign qwin = (item.qid >= win_low) && (item.qid < win_high);
	assign swin = (item.sid >= win_low) && (item.sid < win_high);
	assign drop = (item.qsz < min_len) || (item.ssz < min_len);

	assign iss.valid = (pend_q != 2'b00);
	assign iss.last  = pend_q[0] ? !pend_q[1] : 1'b1;
	assign issue     = iss.valid && take;
	assign in_stall  = iss.valid && !(issue && iss.last);
	assign accept    = in_valid && !in_stall;

	assign route_id = pend_q[0] ? item_q.qid : item_q.sid;
	assign iss.rel  = route_id - win_low;
	assign iss.view = view;

	always_comb begin
		view = item_q;
		if (pend_q[0]) begin
			view.qid     = item_q.sid;
			view.qsz     = item_q.ssz;
			view.qrng    = item_q.srng;
			view.qoff    = item_q.soff;
			view.sid     = item_q.qid;
			view.ssz     = item_q.qsz;
			view.srng    = item_q.qrng;
			view.soff    = item_q.qoff;
			view.strands = {item_q.strands[0], item_q.strands[1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'b00;
		end else if (accept) begin
			pend_q <= drop ? 2'b00 : {swin, qwin};
		end else if (issue) begin
			if (pend_q[0]) begin
				pend_q[0] <= 1'b0;
			end else begin
				pend_q[1] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
	end

endmodule

// ===== rtl/overlap_record_normalize_route.sv =====
// Throughput: one result per cycle while out_stall is low; a request yielding two
// results stalls the input until its second view issues.
// The front holding register issues the views; a restoring divider, one quotient
// bit per stage, sets the pipeline depth.
// Reset (arst_n low, asynchronous): pipeline empty, batch size 1, other configuration registers 0.
`include "assert_macros.svh"
module overlap_record_normalize_route (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic signed [31:0] score,
	input  logic [30:0] query_id,
	input  logic [30:0] query_size,
	input  logic [30:0] subject_id,
	input  logic [30:0] subject_size,
	input  logic [1:0]  strands,
	input  logic [63:0] query_range,
	input  logic [30:0] query_offset,
	input  logic [63:0] subject_range,
	input  logic [30:0] subject_offset,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  partition,
	output logic        last_of_run,
	output logic signed [31:0] out_score,
	output logic [30:0] out_query_id,
	output logic [30:0] out_query_size,
	output logic [30:0] out_subject_id,
	output logic [30:0] out_subject_size,
	output logic [1:0]  out_strands,
	output logic [63:0] out_query_range,
	output logic [30:0] out_query_offset,
	output logic [63:0] out_subject_range,
	output logic [30:0] out_subject_offset
);
	import ornr_pkg::*;

	// configuration
	logic [30:0] batch_q, min_q, low_q, high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_q <= 31'd1;
			min_q   <= '0;
			low_q   <= '0;
			high_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BATCH:    batch_q <= cfg_data;
				CFG_MIN_LEN:  min_q   <= cfg_data;
				CFG_WIN_LOW:  low_q   <= cfg_data;
				CFG_WIN_HIGH: high_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: request holding register, emits up to two views
	rec_t item;
	iss_t iss;
	logic ld [NS];

	always_comb begin
		item.score   = score;
		item.qid     = query_id;
		item.qsz     = query_size;
		item.sid     = subject_id;
		item.ssz     = subject_size;
		item.strands = strands;
		item.qrng    = query_range;
		item.qoff    = query_offset;
		item.srng    = subject_range;
		item.soff    = subject_offset;
	end

	ornr_split u_split (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item     (item),
		.min_len  (min_q),
		.win_low  (low_q),
		.win_high (high_q),
		.take     (ld[0]),
		.iss      (iss)
	);

	// result pipeline
	// stage 0: issued view and offset into window
	// stage 1: normalize, and saturate when rel >= batch << QW
	// stage 2..: one restoring division step per stage, MSB first
	logic pv_s [NS];
	rec_t rec_s [NS];
	dv_t  dv_s [NS];

	// a stage loads when empty or when its contents move on
	always_comb begin
		ld[NS-1] = !pv_s[NS-1] || !out_stall;
		for (int k = NS - 2; k >= 0; k--) begin
			ld[k] = !pv_s[k] || ld[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s[0] <= 1'b0;
		end else if (ld[0]) begin
			pv_s[0] <= iss.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			rec_s[0]     <= iss.view;
			dv_s[0].rem  <= iss.rel;
			dv_s[0].dvs  <= batch_q;
			dv_s[0].q    <= '0;
			dv_s[0].sat  <= 1'b0;
			dv_s[0].last <= iss.last;
		end
	end

	// saturation check; a zero batch size always saturates
	logic sat_ge;
	dv_t  dv_sat;
	assign sat_ge = DW'(dv_s[0].rem) >= (DW'(dv_s[0].dvs) << QW);

	always_comb begin
		dv_sat     = dv_s[0];
		dv_sat.sat = sat_ge;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s[1] <= 1'b0;
		end else if (ld[1]) begin
			pv_s[1] <= pv_s[0];
		end
	end

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			rec_s[1] <= normalize(rec_s[0]);
			dv_s[1]  <= dv_sat;
		end
	end

	for (genvar k = 2; k < NS; k++) begin : g_div
		localparam int BIT = NS - 1 - k;
		logic [DW-1:0] rem_x, sub_x;
		logic          ge;
		dv_t           nxt;

		assign rem_x = DW'(dv_s[k-1].rem);
		assign sub_x = DW'(dv_s[k-1].dvs) << BIT;
		assign ge    = rem_x >= sub_x;

		always_comb begin
			nxt = dv_s[k-1];
			if (ge) begin
				nxt.rem    = 31'(rem_x - sub_x);
				nxt.q[BIT] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pv_s[k] <= 1'b0;
			end else if (ld[k]) begin
				pv_s[k] <= pv_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (ld[k]) begin
				rec_s[k] <= rec_s[k-1];
				dv_s[k]  <= nxt;
			end
		end
	end

	// output
	logic [QW-1:0] part_sat;
	assign part_sat = (dv_s[NS-1].sat || (dv_s[NS-1].q > QW'(PARTITIONS - 1)))
		? QW'(PARTITIONS - 1) : dv_s[NS-1].q;

	assign out_valid          = pv_s[NS-1];
	assign partition          = 4'(part_sat);
	assign last_of_run        = dv_s[NS-1].last;
	assign out_score          = rec_s[NS-1].score;
	assign out_query_id       = rec_s[NS-1].qid;
	assign out_query_size     = rec_s[NS-1].qsz;
	assign out_subject_id     = rec_s[NS-1].sid;
	assign out_subject_size   = rec_s[NS-1].ssz;
	assign out_strands        = rec_s[NS-1].strands;
	assign out_query_range    = rec_s[NS-1].qrng;
	assign out_query_offset   = rec_s[NS-1].qoff;
	assign out_subject_range  = rec_s[NS-1].srng;
	assign out_subject_offset = rec_s[NS-1].soff;

	// checks
	`ORNR_ASSERT(a_stall_busy, in_stall |-> iss.valid, "input stalled with nothing to issue")
	`ORNR_NEVER(a_subj_fwd, out_valid && out_strands[1], "subject not forward on output")
	`ORNR_ASSERT(a_hold_last, (out_valid && out_stall) |=> (out_valid && $stable(last_of_run)), "held")

endmodule
